[src/lgt_pkg.sv]
package lgt_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 64;

   localparam int COL_AW = $clog2(GRID_WIDTH);
   localparam int ROW_AW = $clog2(GRID_HEIGHT);

   localparam logic [1:0] OP_WRITE   = 2'd0;
   localparam logic [1:0] OP_READ    = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   typedef logic [GRID_WIDTH-1:0] row_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] col;
      logic [5:0] row;
      logic       alive_in;
   } req_type;

   typedef struct packed {
      logic       cell_alive;
      logic [1:0] done_operation;
   } rsp_type;

endpackage

[src/lgt_ram.sv]
module lgt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/lgt_row_rule.sv]
module lgt_row_rule
   import lgt_pkg::*;
(
   input  row_type up_row,
   input  row_type cur_row,
   input  row_type down_row,
   output row_type next_row
);

   // one lane per column, neighbors wrap around the row
   for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_lane
      localparam int LEFT  = (c + GRID_WIDTH - 1) % GRID_WIDTH;
      localparam int RIGHT = (c + 1) % GRID_WIDTH;
      logic [3:0] count;

      always_comb begin
         count = 4'(up_row[LEFT]) + 4'(up_row[c]) + 4'(up_row[RIGHT])
               + 4'(cur_row[LEFT]) + 4'(cur_row[RIGHT])
               + 4'(down_row[LEFT]) + 4'(down_row[c]) + 4'(down_row[RIGHT]);
         next_row[c] = (count == 4'd3) || (cur_row[c] && (count == 4'd2));
      end
   end

endmodule

[src/life_generation_torus_unit.sv]
// Toroidal B3/S23 life engine over GRID_HEIGHT rows of GRID_WIDTH cells, held
// one row per word in a single-port-write, single-port-read RAM. A request
// word writes a cell (S_WR, skipped outside the grid), reads a cell (S_RD) or
// advances one generation (S_A1, S_A2, then S_SWEEP over every row); each then
// raises its result from S_DONE, and the next word can be accepted in the same
// cycle as the result is raised.
// The advance is limited by the RAM: one row is read and one new row written
// per cycle, through one shared row-update unit, with the row above and the
// old row 0 kept in registers. One request is in flight at a time; a result
// waiting on rsp_stall does not block the next request from being accepted.
// The grid reads as all dead after reset with no clearing pass.
module life_generation_torus_unit
   import lgt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WR    = 3'd1;
   localparam logic [2:0] S_RD    = 3'd2;
   localparam logic [2:0] S_A1    = 3'd3;
   localparam logic [2:0] S_A2    = 3'd4;
   localparam logic [2:0] S_SWEEP = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(GRID_HEIGHT - 1);

   logic [2:0]             state_ff, state_in;
   logic [1:0]             op_ff, op_in;
   logic [COL_AW-1:0]      col_ff, col_in;
   logic [ROW_AW-1:0]      row_ff, row_in;
   logic                   alive_in_ff, alive_in_in;
   logic                   inside_ff, inside_in;
   logic                   res_alive_ff, res_alive_in;
   logic [ROW_AW-1:0]      r_ff, r_in;
   row_type                prev_row_ff, prev_row_in;
   row_type                cur_row_ff, cur_row_in;
   row_type                first_row_copy_ff, first_row_copy_in;
   logic [GRID_HEIGHT-1:0] row_valid_ff, row_valid_in;
   logic                   rd_valid_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic              req_accept;
   logic              req_inside;
   logic              out_free;
   logic              ram_wr_en;
   logic [ROW_AW-1:0] ram_wr_addr;
   row_type           ram_wr_data;
   logic [ROW_AW-1:0] ram_rd_addr;
   row_type           ram_rd_data;
   row_type           old_row;
   row_type           down_row;
   row_type           new_row;
   logic [31:0]       ahead_idx;

   lgt_ram #(
      .WIDTH(GRID_WIDTH),
      .DEPTH(GRID_HEIGHT)
   ) u_grid (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   lgt_row_rule u_rule (
      .up_row  (prev_row_ff),
      .cur_row (cur_row_ff),
      .down_row(down_row),
      .next_row(new_row)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_inside = (32'(req_payload.col) < 32'(GRID_WIDTH))
                    && (32'(req_payload.row) < 32'(GRID_HEIGHT));
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // rows never written still read as dead
   assign old_row   = rd_valid_ff ? ram_rd_data : '0;
   assign down_row  = (r_ff == LAST_ROW) ? first_row_copy_ff : old_row;
   assign ahead_idx = 32'(r_ff) + 32'd2;

   always_comb begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_payload.operation == OP_ADVANCE) begin
               ram_rd_addr = LAST_ROW;
            end else if (req_inside) begin
               ram_rd_addr = ROW_AW'(req_payload.row);
            end else begin
               ram_rd_addr = '0;
            end
         end
         S_A1:    ram_rd_addr = '0;
         S_A2:    ram_rd_addr = ROW_AW'(1);
         S_SWEEP: ram_rd_addr = (ahead_idx < 32'(GRID_HEIGHT)) ? ROW_AW'(ahead_idx) : '0;
         default: ram_rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in          = state_ff;
      op_in             = op_ff;
      col_in            = col_ff;
      row_in            = row_ff;
      alive_in_in       = alive_in_ff;
      inside_in         = inside_ff;
      res_alive_in      = res_alive_ff;
      r_in              = r_ff;
      prev_row_in       = prev_row_ff;
      cur_row_in        = cur_row_ff;
      first_row_copy_in = first_row_copy_ff;
      row_valid_in      = row_valid_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_in            = rsp_ff;
      ram_wr_en         = 1'b0;
      ram_wr_addr       = row_ff;
      ram_wr_data       = old_row;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               op_in        = req_payload.operation;
               col_in       = COL_AW'(req_payload.col);
               row_in       = ROW_AW'(req_payload.row);
               alive_in_in  = req_payload.alive_in;
               inside_in    = req_inside;
               res_alive_in = 1'b0;
               unique case (req_payload.operation)
                  OP_WRITE:   state_in = req_inside ? S_WR : S_DONE;
                  OP_READ:    state_in = S_RD;
                  OP_ADVANCE: state_in = S_A1;
                  OP_NOP:     state_in = S_DONE;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_WR: begin
            // read-modify-write of one bit in the addressed row
            ram_wr_en           = 1'b1;
            ram_wr_data[col_ff] = alive_in_ff;
            row_valid_in[row_ff] = 1'b1;
            state_in            = S_DONE;
         end
         S_RD: begin
            res_alive_in = inside_ff && old_row[col_ff];
            state_in     = S_DONE;
         end
         S_A1: begin
            prev_row_in = old_row;
            state_in    = S_A2;
         end
         S_A2: begin
            first_row_copy_in = old_row;
            cur_row_in        = old_row;
            r_in              = '0;
            state_in          = S_SWEEP;
         end
         S_SWEEP: begin
            // old row r+1 arrives as new row r is written
            ram_wr_en          = 1'b1;
            ram_wr_addr        = r_ff;
            ram_wr_data        = new_row;
            row_valid_in[r_ff] = 1'b1;
            prev_row_in        = cur_row_ff;
            cur_row_in         = old_row;
            r_in               = r_ff + ROW_AW'(1);
            if (r_ff == LAST_ROW) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.cell_alive     = res_alive_ff;
               rsp_in.done_operation = op_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= row_valid_ff[ram_rd_addr];
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff             <= op_in;
      col_ff            <= col_in;
      row_ff            <= row_in;
      alive_in_ff       <= alive_in_in;
      inside_ff         <= inside_in;
      res_alive_ff      <= res_alive_in;
      r_ff              <= r_in;
      prev_row_ff       <= prev_row_in;
      cur_row_ff        <= cur_row_in;
      first_row_copy_ff <= first_row_copy_in;
      rsp_ff            <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result word raised outside completion");

   a_sweep_no_collision: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP |-> ram_wr_addr != ram_rd_addr)
      else $error("sweep writes the row it reads ahead");

   a_sweep_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SWEEP |-> 32'(r_ff) < 32'(GRID_HEIGHT))
      else $error("sweep row out of range");
`endif

endmodule
